// ----- src/htfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step function for the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam int RAW_W      = 20;
    localparam int HUM_C_W    = 14;
    localparam int TEMP_C_W   = 15;
    localparam int CRC_W      = 8;
    localparam int IDX_W      = 3;

    localparam logic [CRC_W-1:0] CRC_INIT  = 8'hFF;
    localparam logic [CRC_W-1:0] CRC_POLY  = 8'h31;

    // Byte positions inside a frame
    localparam logic [IDX_W-1:0] POS_IDLE    = 3'd0;
    localparam logic [IDX_W-1:0] POS_HUM_HI  = 3'd1;
    localparam logic [IDX_W-1:0] POS_HUM_MID = 3'd2;
    localparam logic [IDX_W-1:0] POS_SPLIT   = 3'd3;
    localparam logic [IDX_W-1:0] POS_TMP_MID = 3'd4;
    localparam logic [IDX_W-1:0] POS_TMP_LO  = 3'd5;
    localparam logic [IDX_W-1:0] POS_CRC     = 3'd6;

    // Fixed-point scale factors: value = (raw * scale) >> RAW_W, less TEMP_OFFSET for temperature
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [RAW_W-1:0]     hum_raw;
        logic [RAW_W-1:0]     temp_raw;
        logic [CRC_W-1:0]     crc;
    } t_frame_rec;

    // One byte through CRC-8, MSB first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/htfd_frame_asm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_frame_asm
// Tracks the byte position, runs the CRC and assembles the raw fields. On the
// CRC byte it loads one frame record into a register for the scaling stage.
// ----------------------------------------------------------------------------
module htfd_frame_asm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_frame_start,
    input  logic                    i_advance,
    output logic                    o_ready,
    output logic                    o_rec_valid,
    output htfd_pkg::t_frame_rec    o_rec
);
    import htfd_pkg::*;

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic             r_busy, n_busy;
    logic [RAW_W-1:0] r_hum, n_hum;
    logic [RAW_W-1:0] r_temp, n_temp;
    logic             r_rec_valid, n_rec_valid;
    t_frame_rec       r_rec, n_rec;
    logic             w_accept;
    logic             w_emit;

    assign o_ready     = !r_rec_valid || i_advance;
    assign w_accept    = i_valid && o_ready;
    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    always_comb begin
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_busy       = r_busy;
        n_hum        = r_hum;
        n_temp       = r_temp;
        n_rec        = r_rec;
        w_emit       = 1'b0;

        if (w_accept) begin
            if (i_frame_start) begin
                // abandon any frame in progress
                n_crc        = crc_fold(CRC_INIT, i_data_byte);
                n_busy       = i_data_byte[7];
                n_hum        = '0;
                n_temp       = '0;
                n_byte_index = POS_HUM_HI;
            end else begin
                case (r_byte_index)
                    POS_HUM_HI: begin
                        n_hum = {i_data_byte, 12'd0};
                    end
                    POS_HUM_MID: begin
                        n_hum = r_hum | {8'd0, i_data_byte, 4'd0};
                    end
                    POS_SPLIT: begin
                        n_hum  = r_hum | {16'd0, i_data_byte[7:4]};
                        n_temp = {i_data_byte[3:0], 16'd0};
                    end
                    POS_TMP_MID: begin
                        n_temp = r_temp | {4'd0, i_data_byte, 8'd0};
                    end
                    POS_TMP_LO: begin
                        n_temp = r_temp | {12'd0, i_data_byte};
                    end
                    default: begin
                    end
                endcase

                if (r_byte_index inside {[POS_HUM_HI:POS_TMP_LO]}) begin
                    n_crc        = crc_fold(r_crc, i_data_byte);
                    n_byte_index = r_byte_index + 1'b1;
                end else if (r_byte_index == POS_CRC) begin
                    w_emit       = 1'b1;
                    n_byte_index = POS_IDLE;
                    n_rec.hum_raw  = r_hum;
                    n_rec.temp_raw = r_temp;
                    n_rec.crc      = r_crc;
                    if (r_busy) begin
                        n_rec.status = ST_BUSY;
                    end else if (r_crc != i_data_byte) begin
                        n_rec.status = ST_CRC_ERR;
                    end else begin
                        n_rec.status = ST_OK;
                    end
                end
            end
        end

        if (w_emit) begin
            n_rec_valid = 1'b1;
        end else if (i_advance) begin
            n_rec_valid = 1'b0;
        end else begin
            n_rec_valid = r_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= POS_IDLE;
            r_crc        <= CRC_INIT;
            r_busy       <= 1'b0;
            r_hum        <= '0;
            r_temp       <= '0;
            r_rec_valid  <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_busy       <= n_busy;
            r_hum        <= n_hum;
            r_temp       <= n_temp;
            r_rec_valid  <= n_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ----- src/htfd_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_scale
// Converts the raw readings to hundredths in fixed point and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module htfd_scale (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rec_valid,
    input  htfd_pkg::t_frame_rec    i_rec,
    input  logic                    i_ready,
    output logic                    o_advance,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [19:0]             o_humidity_raw,
    output logic [19:0]             o_temperature_raw,
    output logic [13:0]             o_humidity_centi,
    output logic signed [14:0]      o_temperature_centi,
    output logic [7:0]              o_crc_computed
);
    import htfd_pkg::*;

    localparam int HUM_PROD_W  = RAW_W + HUM_C_W;
    localparam int TEMP_PROD_W = RAW_W + TEMP_C_W;

    logic                       r_valid;
    t_frame_rec                 r_rec;
    logic [HUM_C_W-1:0]         r_hum_c;
    logic signed [TEMP_C_W-1:0] r_temp_c;
    logic [HUM_PROD_W-1:0]      w_hum_prod;
    logic [TEMP_PROD_W-1:0]     w_temp_prod;
    logic [TEMP_C_W-1:0]        w_temp_c;

    assign o_advance = !r_valid || i_ready;

    assign w_hum_prod  = HUM_PROD_W'(i_rec.hum_raw) * HUM_PROD_W'(HUM_SCALE);
    assign w_temp_prod = TEMP_PROD_W'(i_rec.temp_raw) * TEMP_PROD_W'(TEMP_SCALE);
    // truncate the shifted product, then remove the offset
    assign w_temp_c    = w_temp_prod[TEMP_PROD_W-1:RAW_W] - TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_rec_valid) begin
            r_rec    <= i_rec;
            r_hum_c  <= w_hum_prod[HUM_PROD_W-1:RAW_W];
            r_temp_c <= signed'(w_temp_c);
        end
    end

    assign o_valid             = r_valid;
    assign o_status            = r_rec.status;
    assign o_humidity_raw      = r_rec.hum_raw;
    assign o_temperature_raw   = r_rec.temp_raw;
    assign o_humidity_centi    = r_hum_c;
    assign o_temperature_centi = r_temp_c;
    assign o_crc_computed      = r_rec.crc;

endmodule

// ----- src/humidity_temp_frame_decoder.sv -----
`timescale 1ns / 1ps
// Throughput: one byte per cycle while o_ready is high; a frame of seven bytes
// gives one result. The frame record register loads at the edge that accepts the
// CRC byte and the output register loads from it once the output stage advances;
// the CRC compare sits before the record register, the scaling multipliers after it.
// Reset (synchronous, active low) returns to idle with CRC 0xFF and no result.
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes the seven-byte humidity/temperature sensor response, checks its
// CRC-8 and returns raw and scaled readings with a status.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_frame_start,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [19:0]         o_humidity_raw,
    output logic [19:0]         o_temperature_raw,
    output logic [13:0]         o_humidity_centi,
    output logic signed [14:0]  o_temperature_centi,
    output logic [7:0]          o_crc_computed
);
    import htfd_pkg::*;

    logic       w_rec_valid;
    t_frame_rec w_rec;
    logic       w_advance;

    htfd_frame_asm u_frame_asm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_advance     (w_advance),
        .o_ready       (o_ready),
        .o_rec_valid   (w_rec_valid),
        .o_rec         (w_rec)
    );

    htfd_scale u_scale (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rec_valid         (w_rec_valid),
        .i_rec               (w_rec),
        .i_ready             (i_ready),
        .o_advance           (w_advance),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_humidity_raw      (o_humidity_raw),
        .o_temperature_raw   (o_temperature_raw),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_centi (o_temperature_centi),
        .o_crc_computed      (o_crc_computed)
    );

endmodule

// ----- src/htfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_frame_start,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [1:0]          o_status,
    input  logic [19:0]         o_humidity_raw,
    input  logic [19:0]         o_temperature_raw,
    input  logic [13:0]         o_humidity_centi,
    input  logic signed [14:0]  o_temperature_centi,
    input  logic [7:0]          o_crc_computed
);
    import htfd_pkg::*;

    // no result may appear right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data_byte)
            && $stable(i_frame_start))
        else $error("waiting input changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_humidity_raw) && $stable(o_temperature_raw)
            && $stable(o_humidity_centi) && $stable(o_temperature_centi)
            && $stable(o_crc_computed))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_BUSY)
            || (o_status == ST_CRC_ERR))
        else $error("unused status code");

    // scaled humidity must follow from the raw value shown with it
    a_hum_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_humidity_centi
            == 14'((34'(o_humidity_raw) * 34'd10000) >> 20))
        else $error("humidity scaling mismatch");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

// ----- dv/tb_humidity_temp_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder
// Self-checking bench for the sensor frame decoder. Bytes are driven through
// the input handshake while a local decoder model tracks the frame position,
// CRC-8, busy flag and raw fields, and queues the reading that each CRC byte
// should produce. A checker compares every output transaction, field by field,
// against the oldest queued reading. Directed frames cover the extremes and
// the abandoned-frame, idle-byte, busy and CRC error cases; random traffic
// mixes well-formed frames with truncated frames and noise, under random
// idling on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_decoder;
    import htfd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct {
        t_status               status;
        logic [RAW_W-1:0]      hum_raw;
        logic [RAW_W-1:0]      temp_raw;
        logic [HUM_C_W-1:0]    hum_centi;
        logic [TEMP_C_W-1:0]   temp_centi;
        logic [CRC_W-1:0]      crc;
    } t_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_data_byte = 8'h00;
    logic                i_frame_start = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [1:0]          o_status;
    logic [19:0]         o_humidity_raw;
    logic [19:0]         o_temperature_raw;
    logic [13:0]         o_humidity_centi;
    logic signed [14:0]  o_temperature_centi;
    logic [7:0]          o_crc_computed;

    humidity_temp_frame_decoder DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_humidity_raw      (o_humidity_raw),
        .o_temperature_raw   (o_temperature_raw),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_centi (o_temperature_centi),
        .o_crc_computed      (o_crc_computed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Local decoder state
    logic [IDX_W-1:0]  frm_pos   = POS_IDLE;
    logic [CRC_W-1:0]  crc_run   = CRC_INIT;
    logic              busy_flag = 1'b0;
    logic [RAW_W-1:0]  hum_acc   = '0;
    logic [RAW_W-1:0]  tmp_acc   = '0;

    t_reading pending_readings[$];

    int errors          = 0;
    int cycles          = 0;
    int bytes_sent      = 0;
    int effective_items = 0;
    int ignored_bytes   = 0;
    int readings_seen   = 0;
    int status_tally[3] = '{0, 0, 0};

    // Traffic shaping
    bit tx_no_gaps    = 1'b0;
    bit rx_always     = 1'b0;
    int hold_req_cnt  = 0;
    int hold_seen_cnt = 0;
    int rx_left       = 0;
    bit rx_low        = 1'b0;

    function automatic logic [CRC_W-1:0] crc8_update(input logic [CRC_W-1:0] acc,
                                                     input logic [7:0] d);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[CRC_W-1] ^ d[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'h00;
        if (r < 16) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Advance the local decoder by one accepted byte; queue a reading on the CRC byte
    task automatic decode_byte(input logic [7:0] b, input logic st, output bit took);
        logic [33:0] hum_prod;
        logic [34:0] tmp_prod;
        int          tmp_val;
        t_reading    rd;
        took = 1'b1;
        if (st) begin
            crc_run   = crc8_update(CRC_INIT, b);
            busy_flag = b[7];
            hum_acc   = '0;
            tmp_acc   = '0;
            frm_pos   = POS_HUM_HI;
        end else if (frm_pos == POS_IDLE || frm_pos > POS_CRC) begin
            took = 1'b0;
        end else begin
            case (frm_pos)
                POS_HUM_HI: begin
                    hum_acc = {b, 12'h000};
                end
                POS_HUM_MID: begin
                    hum_acc = hum_acc | {8'h00, b, 4'h0};
                end
                POS_SPLIT: begin
                    hum_acc = hum_acc | {16'h0000, b[7:4]};
                    tmp_acc = {b[3:0], 16'h0000};
                end
                POS_TMP_MID: begin
                    tmp_acc = tmp_acc | {4'h0, b, 8'h00};
                end
                POS_TMP_LO: begin
                    tmp_acc = tmp_acc | {12'h000, b};
                end
                default: ;
            endcase
            if (frm_pos != POS_CRC) begin
                crc_run = crc8_update(crc_run, b);
                frm_pos = frm_pos + 1'b1;
            end else begin
                if (busy_flag) begin
                    rd.status = ST_BUSY;
                end else if (crc_run != b) begin
                    rd.status = ST_CRC_ERR;
                end else begin
                    rd.status = ST_OK;
                end
                hum_prod      = hum_acc * HUM_SCALE;
                tmp_prod      = tmp_acc * TEMP_SCALE;
                tmp_val       = int'(tmp_prod >> RAW_W) - int'(TEMP_OFFSET);
                rd.hum_raw    = hum_acc;
                rd.temp_raw   = tmp_acc;
                rd.hum_centi  = hum_prod[33:20];
                rd.temp_centi = tmp_val[14:0];
                rd.crc        = crc_run;
                pending_readings.push_back(rd);
                frm_pos = POS_IDLE;
            end
        end
    endtask

    // Offer one byte and hold it until accepted; call at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        bit took;
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= st;
        do @(posedge i_clk); while (!o_ready);
        decode_byte(b, st, took);
        bytes_sent++;
        if (took) begin
            effective_items++;
        end else begin
            ignored_bytes++;
        end
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send a frame, or its first n bytes; byte 6 carries a good or corrupted CRC
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] d1, input logic [7:0] d2,
                              input logic [7:0] d3, input logic [7:0] d4, input logic [7:0] d5,
                              input bit good_crc, input int n);
        logic [7:0] fb[7];
        logic [7:0] c;
        fb[0] = b0; fb[1] = d1; fb[2] = d2; fb[3] = d3; fb[4] = d4; fb[5] = d5;
        c = crc8_update(CRC_INIT, fb[0]);
        for (int i = 1; i < 6; i++) begin
            c = crc8_update(c, fb[i]);
        end
        fb[6] = good_crc ? c : c ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < n; i++) begin
            send_byte(fb[i], i == 0);
        end
    endtask

    task automatic send_random_frame(input bit busy, input bit good_crc, input int n);
        logic [7:0] b0;
        b0 = {busy, 7'($urandom_range(0, 127))};
        send_frame(b0, rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   good_crc, n);
    endtask

    // Drop valid and hold until every queued reading has come out
    task automatic wait_for_readings();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    task automatic test_directed_frames();
        send_byte(8'hA5, 1'b0);                                          // idle byte, ignored
        send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 7);   // full scale, ok
        send_byte(8'h18, 1'b1);                                          // frame left unfinished
        send_byte(8'h12, 1'b0);
        send_frame(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 7);   // busy wins over bad CRC
        send_frame(8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 7);   // zero scale, bad CRC
        wait_for_readings();
    endtask

    task automatic test_random_traffic();
        int r;
        int seg;
        int start_items;
        start_items = effective_items;
        while (effective_items - start_items < RANDOM_ITEMS) begin
            // Every fourth stretch runs with no idling on either side
            seg        = (effective_items - start_items) / 100;
            tx_no_gaps = (seg % 4 == 3);
            rx_always  = tx_no_gaps;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_random_frame($urandom_range(0, 99) < 20, $urandom_range(0, 99) < 80, 7);
            end else if (r < 80) begin
                send_random_frame($urandom_range(0, 1), 1'b1, $urandom_range(1, 6));
            end else if (r < 88) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(rand_byte(), $urandom_range(0, 99) < 15);
                end
            end else if (r < 94) begin
                send_byte(rand_byte(), 1'b0);
            end else if ($urandom_range(0, 1)) begin
                send_frame({1'b0, 7'($urandom_range(0, 127))}, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                           8'hFF, 1'b1, 7);
            end else begin
                send_frame({1'b0, 7'($urandom_range(0, 127))}, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 1'b1, 7);
            end
        end
        tx_no_gaps = 1'b0;
        rx_always  = 1'b0;
        wait_for_readings();
    endtask

    // Stall the output for a long stretch while bytes keep coming back to back
    task automatic test_output_stall();
        hold_req_cnt++;
        tx_no_gaps = 1'b1;
        repeat (6) begin
            send_random_frame(1'b0, $urandom_range(0, 1), 7);
        end
        tx_no_gaps = 1'b0;
        wait_for_readings();
    endtask

    task automatic test_pause_and_resume();
        repeat (2) begin
            send_random_frame($urandom_range(0, 1), 1'b1, 7);
            send_random_frame(1'b0, 1'b1, 7);
            send_random_frame(1'b0, 1'b0, 7);
            wait_for_readings();
        end
    endtask

    // Output ready: random stretches high and low, held high in no-idle stretches, or a long requested hold
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            rx_low        = 1'b1;
            rx_left       = LONG_HOLD;
        end else if (rx_left == 0) begin
            if (rx_always) begin
                rx_low  = 1'b0;
                rx_left = 1;
            end else begin
                rx_low  = ($urandom_range(0, 99) < 35);
                rx_left = rx_low ? pick_gap() + 1 : $urandom_range(1, 20);
            end
        end
        rx_left = rx_left - 1;
        i_ready <= !rx_low;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reading rd;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t ns: unexpected reading, expected none, actual status %0h crc %0h",
                         $time, o_status, o_crc_computed);
                errors++;
            end else begin
                rd = pending_readings.pop_front();
                check_field("status", {30'd0, rd.status}, {30'd0, o_status});
                check_field("humidity_raw", {12'd0, rd.hum_raw}, {12'd0, o_humidity_raw});
                check_field("temperature_raw", {12'd0, rd.temp_raw},
                            {12'd0, o_temperature_raw});
                check_field("humidity_centi", {18'd0, rd.hum_centi},
                            {18'd0, o_humidity_centi});
                check_field("temperature_centi", {17'd0, rd.temp_centi},
                            {17'd0, o_temperature_centi});
                check_field("crc_computed", {24'd0, rd.crc}, {24'd0, o_crc_computed});
                readings_seen++;
                status_tally[rd.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d readings still pending",
                     $time, pending_readings.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_random_traffic();
        test_output_stall();
        test_pause_and_resume();
        wait_for_readings();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Drove %0d bytes (%0d decoded, %0d ignored while idle) in %0d cycles",
                 bytes_sent, effective_items, ignored_bytes, cycles);
        $display("Checked %0d readings: %0d ok, %0d busy, %0d CRC error, %0d errors",
                 readings_seen, status_tally[ST_OK], status_tally[ST_BUSY],
                 status_tally[ST_CRC_ERR], errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
